// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the keypad scanner checkers.
// Needs a signal named clk and, for the gated form, one named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define KPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define KPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/kps_pkg.sv -----
// Package for the 4x4 keypad scanner: types, reset values, key code table.
// No dependencies; used by kps_step, kps_out_queue and the top level.
`default_nettype none

package kps_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b1;

  localparam logic [7:0]  SETTLE_RESET   = 8'd100;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd20000;
  localparam logic [3:0]  LINES_IDLE     = 4'hf;
  localparam logic [1:0]  LAST_ROW       = 2'd3;

  typedef enum logic [2:0] {
    PH_PRESS   = 3'd0,
    PH_DELAY1  = 3'd1,
    PH_CONFIRM = 3'd2,
    PH_RELEASE = 3'd3,
    PH_DELAY2  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    SCAN_BUSY  = 2'd0,
    SCAN_KEY   = 2'd1,
    SCAN_EMPTY = 2'd2
  } scan_res_t;

  typedef struct packed {
    logic [7:0]  settle_ticks;
    logic [15:0] debounce_ticks;
  } kps_cfg_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_valid;
    logic [7:0] key_code;
  } kps_result_t;

  // Row-major key layout: "123A" "456B" "789C" "*0#D"
  function automatic logic [7:0] key_ascii(input logic [3:0] key);
    logic [7:0] code;
    case (key)
      4'd0:    code = 8'h31;
      4'd1:    code = 8'h32;
      4'd2:    code = 8'h33;
      4'd3:    code = 8'h41;
      4'd4:    code = 8'h34;
      4'd5:    code = 8'h35;
      4'd6:    code = 8'h36;
      4'd7:    code = 8'h42;
      4'd8:    code = 8'h37;
      4'd9:    code = 8'h38;
      4'd10:   code = 8'h39;
      4'd11:   code = 8'h43;
      4'd12:   code = 8'h2a;
      4'd13:   code = 8'h30;
      4'd14:   code = 8'h23;
      4'd15:   code = 8'h44;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/kps_if.sv -----
// Valid/ready channels of the keypad scanner: column samples in, results out.
// Depends on nothing.
`default_nettype none

interface kps_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] col_levels;

  modport source (output valid, output col_levels, input ready);
  modport sink   (input valid, input col_levels, output ready);
endinterface

interface kps_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] row_drive;
  logic       key_valid;
  logic [7:0] key_code;

  modport source (output valid, output row_drive, output key_valid, output key_code,
                  input ready);
  modport sink   (input valid, input row_drive, input key_valid, input key_code,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/kps_step.sv -----
// Scan/debounce state and the single-tick step logic.
// Depends on kps_pkg.
`default_nettype none

module kps_step (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire kps_pkg::kps_cfg_t   cfg,
  input  wire logic                step_en,
  input  wire logic [3:0]          col_levels,
  output kps_pkg::kps_result_t     result
);
  import kps_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  row_index, row_index_next;
  logic [7:0]  settle_count, settle_count_next;
  logic [15:0] delay_count, delay_count_next;
  logic [3:0]  candidate_key, candidate_key_next;

  logic        settle_done, delay_done, hit;
  logic [1:0]  hit_col;
  logic [1:0]  scan_row;
  logic [7:0]  scan_settle;
  logic [3:0]  scan_key;
  scan_res_t   scan_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_PRESS;
      row_index     <= '0;
      settle_count  <= '0;
      delay_count   <= '0;
      candidate_key <= '0;
    end else if (step_en) begin
      phase         <= phase_next;
      row_index     <= row_index_next;
      settle_count  <= settle_count_next;
      delay_count   <= delay_count_next;
      candidate_key <= candidate_key_next;
    end
  end

  always_comb begin
    // lowest pulled-down column wins
    hit_col = 2'd0;
    for (int c = 3; c >= 0; c--) begin
      if (!col_levels[c]) hit_col = 2'(c);
    end
    hit         = (col_levels != LINES_IDLE);
    settle_done = (settle_count >= cfg.settle_ticks);
    delay_done  = (delay_count >= cfg.debounce_ticks);
    scan_key    = {row_index, hit_col};

    scan_row    = row_index;
    scan_settle = settle_count;
    scan_res    = SCAN_BUSY;
    if (!settle_done) begin
      scan_settle = settle_count + 8'd1;
    end else if (hit) begin
      scan_res = SCAN_KEY;
    end else if (row_index == LAST_ROW) begin
      scan_res = SCAN_EMPTY;
    end else begin
      scan_row    = row_index + 2'd1;
      scan_settle = '0;
    end
  end

  always_comb begin
    phase_next         = phase;
    row_index_next     = row_index;
    settle_count_next  = settle_count;
    delay_count_next   = delay_count;
    candidate_key_next = candidate_key;
    result.row_drive   = ~(4'b0001 << row_index);
    result.key_valid   = 1'b0;
    result.key_code    = 8'h00;

    case (phase)
      PH_DELAY1: begin
        result.row_drive = LINES_IDLE;
        if (delay_done) begin
          phase_next        = PH_CONFIRM;
          row_index_next    = '0;
          settle_count_next = '0;
        end else begin
          delay_count_next = delay_count + 16'd1;
        end
      end
      PH_DELAY2: begin
        result.row_drive = LINES_IDLE;
        if (delay_done) begin
          result.key_valid  = 1'b1;
          result.key_code   = key_ascii(candidate_key);
          phase_next        = PH_PRESS;
          row_index_next    = '0;
          settle_count_next = '0;
        end else begin
          delay_count_next = delay_count + 16'd1;
        end
      end
      PH_CONFIRM: begin
        row_index_next    = scan_row;
        settle_count_next = scan_settle;
        if (scan_res == SCAN_KEY && scan_key == candidate_key) begin
          phase_next        = PH_RELEASE;
          row_index_next    = '0;
          settle_count_next = '0;
        end else if (scan_res != SCAN_BUSY) begin
          phase_next        = PH_PRESS;
          row_index_next    = '0;
          settle_count_next = '0;
        end
      end
      PH_RELEASE: begin
        row_index_next    = scan_row;
        settle_count_next = scan_settle;
        if (scan_res == SCAN_KEY) begin
          row_index_next    = '0;
          settle_count_next = '0;
        end else if (scan_res == SCAN_EMPTY) begin
          phase_next       = PH_DELAY2;
          delay_count_next = '0;
        end
      end
      default: begin
        phase_next        = PH_PRESS;
        row_index_next    = scan_row;
        settle_count_next = scan_settle;
        if (scan_res == SCAN_KEY) begin
          candidate_key_next = scan_key;
          phase_next         = PH_DELAY1;
          delay_count_next   = '0;
        end else if (scan_res == SCAN_EMPTY) begin
          row_index_next    = '0;
          settle_count_next = '0;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/kps_out_queue.sv -----
// Two-entry result queue: two entries addressed by read and write pointers.
// Depends on kps_pkg and kps_out_if.
`default_nettype none

module kps_out_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire kps_pkg::kps_result_t push_data,
  output logic                      full,
  kps_out_if.source                 result
);
  import kps_pkg::*;

  kps_result_t entry [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop  = result.valid && result.ready;
  assign full = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  assign result.valid     = (count != 2'd0);
  assign result.row_drive = entry[rd_ptr].row_drive;
  assign result.key_valid = entry[rd_ptr].key_valid;
  assign result.key_code  = entry[rd_ptr].key_code;

endmodule

`default_nettype wire

// ----- rtl/matrix_keypad_scanner_debounce.sv -----
// Top level of the 4x4 keypad scanner with debounce.
// Depends on kps_pkg, kps_if, kps_step and kps_out_queue.
//
// Each request on sample carries one scan tick's column levels and yields
// exactly one request on result (row drive, key flag, ASCII code). One
// request is taken every cycle while the result queue is not full; a sample
// passes the input register, then the scan/debounce step into the two-entry
// result queue, so a sample is still taken while one result waits.
// The user writes settle_ticks (index 0) and debounce_ticks (index 1) through
// cfg_we/cfg_index/cfg_data while no request is in flight; nothing enforces it.
`default_nettype none

module matrix_keypad_scanner_debounce (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [kps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [kps_pkg::CFG_DATA_W-1:0]   cfg_data,
  kps_in_if.sink                                sample,
  kps_out_if.source                             result
);
  import kps_pkg::*;

  kps_cfg_t    cfg;
  logic        in_valid;
  logic [3:0]  in_cols;
  logic        q_full;
  logic        advance;
  kps_result_t step_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks   <= SETTLE_RESET;
      cfg.debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETTLE:   cfg.settle_ticks   <= cfg_data[7:0];
        CFG_DEBOUNCE: cfg.debounce_ticks <= cfg_data[15:0];
        default:      cfg <= cfg;
      endcase
    end
  end

  assign advance      = in_valid && !q_full;
  assign sample.ready = !in_valid || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) in_cols <= sample.col_levels;
  end

  kps_step u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step_en    (advance),
    .col_levels (in_cols),
    .result     (step_result)
  );

  kps_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (step_result),
    .full      (q_full),
    .result    (result)
  );

endmodule

`default_nettype wire

// ----- rtl/kps_checker.sv -----
// Port-level checks for the keypad scanner, bound to the top level.
// Depends on assert_macros.svh and matrix_keypad_scanner_debounce.
`default_nettype none
`include "assert_macros.svh"

module kps_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] row_drive,
  input wire logic       key_valid,
  input wire logic [7:0] key_code
);

  `KPS_ASSERT_ALWAYS(a_empty_after_reset, rst |=> !out_valid, "result valid right after reset")
  `KPS_ASSERT(a_report_rows_idle, (out_valid && key_valid) |-> (row_drive == 4'hf), "key reported while a row is driven")
  `KPS_ASSERT(a_code_zero_idle, (out_valid && !key_valid) |-> (key_code == 8'h00), "nonzero code without key")
  `KPS_ASSERT(a_one_row_low, out_valid |-> ($countones(row_drive) == 3 || $countones(row_drive) == 4), "more than one row driven")
  `KPS_ASSERT(a_stall_hold, (out_valid && !out_ready) |=> (out_valid && $stable(row_drive) && $stable(key_valid) && $stable(key_code)), "stalled result changed")

endmodule

bind matrix_keypad_scanner_debounce kps_checker u_kps_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .row_drive (result.row_drive),
  .key_valid (result.key_valid),
  .key_code  (result.key_code)
);

`default_nettype wire
